### rtl/sorted_array_priority_queue_macros.svh
// assertion helpers for the sorted array priority queue
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// property that holds in every cycle out of reset
`define SAPQ_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("sapq check failed");

// consequence in the cycle after the trigger
`define SAPQ_NEXT(label, trig, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("sapq check failed");

`endif

### rtl/sapq_pkg.sv
package sapq_pkg;

   localparam int DEPTH_DEFAULT    = 64;
   localparam int KEY_BITS_DEFAULT = 16;
   localparam int TAG_BITS_DEFAULT = 16;
   localparam int MODE_BITS        = 3;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_OFFER      = 3'd0,
      MODE_POLL       = 3'd1,
      MODE_PEEK       = 3'd2,
      MODE_READ       = 3'd3,
      MODE_REMOVE_TAG = 3'd4,
      MODE_REMOVE_AT  = 3'd5,
      MODE_SIZE       = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_OFFER,
      CELL_SHIFT
   } cell_cmd_type;

   // per-cell status seen by the controller
   typedef struct packed {
      logic gt;     // holds an entry with a larger key than the offered one
      logic ins;    // takes the offered entry itself
      logic match;  // holds an entry with the tag on the bus
      logic sel;    // sits at the selected position
   } cell_stat_type;

endpackage

### rtl/sapq_cell.sv
module sapq_cell import sapq_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT,
   parameter int TAG_BITS = TAG_BITS_DEFAULT,
   parameter int INDEX    = 0,
   localparam int CW      = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [CW-1:0]       count,
   input  logic [CW-1:0]       thr,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic                left_gt,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [TAG_BITS-1:0] left_tag,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [TAG_BITS-1:0] right_tag,
   output logic [KEY_BITS-1:0] cell_key,
   output logic [TAG_BITS-1:0] cell_tag,
   output cell_stat_type       stat
);

   localparam logic [CW-1:0] POS = CW'(INDEX);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                occupied;
   logic                slot;

   always_comb begin
      occupied   = POS < count;
      stat.gt    = occupied && (new_key < key_ff);
      slot       = stat.gt || (POS == count);
      stat.ins   = slot && !left_gt;
      stat.match = occupied && (tag_ff == new_tag);
      stat.sel   = POS == thr;
      key_in     = key_ff;
      tag_in     = tag_ff;
      unique case (cmd)
         CELL_OFFER: begin
            if (slot) begin
               key_in = left_gt ? left_key : new_key;
               tag_in = left_gt ? left_tag : new_tag;
            end
         end
         CELL_SHIFT: begin
            if (POS >= thr) begin
               key_in = right_key;
               tag_in = right_tag;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign cell_key = key_ff;
   assign cell_tag = tag_ff;

endmodule

### rtl/sorted_array_priority_queue.sv
// sorted array priority queue: a row of DEPTH cells holds (key, tag) entries in
// ascending key order, cell 0 being the head. offer, poll, peek, read at index,
// remove at index and size each show their result with rsp_valid high in the
// cycle after the operation is transferred, and busy stays low, so a new
// operation may be started every cycle while busy is low. remove tag walks the
// row from the head, in each cycle either deleting the matching entry at the scan
// position in place or stepping past a non-matching one, so every match goes;
// busy is high while it runs and its result appears in the cycle where busy falls.
// every result is shown for exactly one cycle and must be taken then: the receiver
// cannot stall it. offer into a full queue is refused with rsp_ok low; fields a
// mode does not produce read zero.
module sorted_array_priority_queue import sapq_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT,
   parameter int TAG_BITS = TAG_BITS_DEFAULT,
   localparam int CW      = $clog2(DEPTH + 1),
   localparam int IW      = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_BITS-1:0] req_mode,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic [TAG_BITS-1:0] req_tag,
   input  logic [IW-1:0]       req_index,
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic [IW-1:0]       rsp_position,
   output logic [KEY_BITS-1:0] rsp_key_out,
   output logic [TAG_BITS-1:0] rsp_tag_out,
   output logic [CW-1:0]       rsp_removed_count,
   output logic [CW-1:0]       rsp_count
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;       // scan position for remove tag
   logic [CW-1:0]       removed_ff, removed_in;
   logic [TAG_BITS-1:0] scan_tag_ff, scan_tag_in;

   logic                valid_ff, valid_in;
   logic                ok_ff, ok_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [KEY_BITS-1:0] kout_ff, kout_in;
   logic [TAG_BITS-1:0] tout_ff, tout_in;
   logic [CW-1:0]       rcnt_ff, rcnt_in;
   logic [CW-1:0]       cnt_out_ff, cnt_out_in;

   cell_cmd_type        cmd;
   logic [CW-1:0]       thr;
   logic [TAG_BITS-1:0] bus_tag;
   logic                accept;
   mode_type            mode;

   logic [KEY_BITS-1:0] cell_key [DEPTH];
   logic [TAG_BITS-1:0] cell_tag [DEPTH];
   cell_stat_type       stat [DEPTH];

   // reductions over the row: insert position from the one-hot ins flags, selected entry, match there
   logic [IW-1:0]       ins_pos;
   logic [KEY_BITS-1:0] sel_key;
   logic [TAG_BITS-1:0] sel_tag;
   logic                sel_match;

   assign accept  = start && (state_ff == ST_IDLE);
   assign mode    = mode_type'(req_mode);
   assign bus_tag = (state_ff == ST_SCAN) ? scan_tag_ff : req_tag;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      sapq_cell #(
         .DEPTH   (DEPTH),
         .KEY_BITS(KEY_BITS),
         .TAG_BITS(TAG_BITS),
         .INDEX   (g)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .count    (count_ff),
         .thr      (thr),
         .new_key  (req_key),
         .new_tag  (bus_tag),
         .left_gt  ((g == 0) ? 1'b0 : stat[(g == 0) ? 0 : g - 1].gt),
         .left_key (cell_key[(g == 0) ? 0 : g - 1]),
         .left_tag (cell_tag[(g == 0) ? 0 : g - 1]),
         .right_key(cell_key[(g == DEPTH - 1) ? g : g + 1]),
         .right_tag(cell_tag[(g == DEPTH - 1) ? g : g + 1]),
         .cell_key (cell_key[g]),
         .cell_tag (cell_tag[g]),
         .stat     (stat[g])
      );
   end

   always_comb begin
      ins_pos   = '0;
      sel_key   = '0;
      sel_tag   = '0;
      sel_match = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (stat[i].ins) ins_pos = ins_pos | IW'(i);
         if (stat[i].sel) begin
            sel_key   = sel_key | cell_key[i];
            sel_tag   = sel_tag | cell_tag[i];
            sel_match = sel_match | stat[i].match;
         end
      end
   end

   // controller
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      removed_in  = removed_ff;
      scan_tag_in = scan_tag_ff;
      cmd         = CELL_HOLD;
      thr         = (state_ff == ST_SCAN) ? ptr_ff : CW'(req_index);
      valid_in    = 1'b0;
      ok_in       = 1'b0;
      pos_in      = '0;
      kout_in     = '0;
      tout_in     = '0;
      rcnt_in     = '0;
      cnt_out_in  = cnt_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in = 1'b1;
               unique case (mode)
                  MODE_OFFER: begin
                     if (count_ff < FULL) begin
                        cmd      = CELL_OFFER;
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                        pos_in   = ins_pos;
                     end
                  end
                  MODE_POLL, MODE_PEEK: begin
                     thr = '0;
                     if (count_ff != '0) begin
                        ok_in   = 1'b1;
                        kout_in = cell_key[0];
                        tout_in = cell_tag[0];
                        if (mode == MODE_POLL) begin
                           cmd      = CELL_SHIFT;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  MODE_READ, MODE_REMOVE_AT: begin
                     if (CW'(req_index) < count_ff) begin
                        ok_in   = 1'b1;
                        kout_in = sel_key;
                        tout_in = sel_tag;
                        if (mode == MODE_REMOVE_AT) begin
                           cmd      = CELL_SHIFT;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  MODE_REMOVE_TAG: begin
                     valid_in    = 1'b0;
                     state_in    = ST_SCAN;
                     ptr_in      = '0;
                     removed_in  = '0;
                     scan_tag_in = req_tag;
                  end
                  MODE_SIZE: ok_in = 1'b1;
                  default: begin
                  end
               endcase
               cnt_out_in = count_in;
            end
         end
         ST_SCAN: begin
            if (ptr_ff < count_ff) begin
               if (sel_match) begin
                  // delete in place, the next entry slides into this position
                  cmd        = CELL_SHIFT;
                  count_in   = count_ff - 1'b1;
                  removed_in = removed_ff + 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else begin
               state_in   = ST_IDLE;
               valid_in   = 1'b1;
               ok_in      = removed_ff != '0;
               rcnt_in    = removed_ff;
               cnt_out_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      ptr_ff      <= ptr_in;
      removed_ff  <= removed_in;
      scan_tag_ff <= scan_tag_in;
      ok_ff       <= ok_in;
      pos_ff      <= pos_in;
      kout_ff     <= kout_in;
      tout_ff     <= tout_in;
      rcnt_ff     <= rcnt_in;
      cnt_out_ff  <= cnt_out_in;
   end

   assign busy              = state_ff == ST_SCAN;
   assign rsp_valid         = valid_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_position      = pos_ff;
   assign rsp_key_out       = kout_ff;
   assign rsp_tag_out       = tout_ff;
   assign rsp_removed_count = rcnt_ff;
   assign rsp_count         = cnt_out_ff;

   `include "sorted_array_priority_queue_macros.svh"

   // entry count never passes the row length
   `SAPQ_ALWAYS(a_count_range, count_ff <= FULL)
   // no result while a tag scan is running
   `SAPQ_ALWAYS(a_quiet_scan, !(busy && rsp_valid))
   // operations other than remove tag answer in the next cycle
   `SAPQ_NEXT(a_fast_answer, accept && (req_mode != MODE_REMOVE_TAG), rsp_valid)
   // a tag scan ends with a result in the cycle where busy has just fallen
   `SAPQ_ALWAYS(a_scan_done, !$fell(busy) || (rsp_valid && (rsp_count == count_ff)))

endmodule

### verif/sorted_array_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_array_priority_queue_tb;
   import sapq_pkg::*;

   localparam int DEPTH = 64;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_mode;
   logic [15:0] req_key;
   logic [15:0] req_tag;
   logic [5:0]  req_index;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [5:0]  rsp_position;
   logic [15:0] rsp_key_out;
   logic [15:0] rsp_tag_out;
   logic [6:0]  rsp_removed_count;
   logic [6:0]  rsp_count;

   // one expected queue answer
   typedef struct packed {
      logic        ok;
      logic [5:0]  position;
      logic [15:0] key_out;
      logic [15:0] tag_out;
      logic [6:0]  removed_count;
      logic [6:0]  count;
   } answer_type;

   answer_type  answers_due[$];
   logic [15:0] shadow_keys[DEPTH];
   logic [15:0] shadow_tags[DEPTH];
   int          shadow_count;
   int          errors;
   bit          no_gaps;

   sorted_array_priority_queue dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_key(req_key), .req_tag(req_tag),
      .req_index(req_index), .rsp_valid(rsp_valid), .rsp_ok(rsp_ok),
      .rsp_position(rsp_position), .rsp_key_out(rsp_key_out),
      .rsp_tag_out(rsp_tag_out), .rsp_removed_count(rsp_removed_count),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // close the gap left at position p
   function automatic void shadow_delete(int p);
      for (int i = p; i + 1 < shadow_count; i++) begin
         shadow_keys[i] = shadow_keys[i + 1];
         shadow_tags[i] = shadow_tags[i + 1];
      end
      shadow_count--;
   endfunction

   // apply one operation to the shadow queue and return the answer it gives
   function automatic answer_type queue_answer(logic [2:0] m, logic [15:0] k,
                                               logic [15:0] t, logic [5:0] ix);
      answer_type a;
      int         p;
      int         w;
      a = '0;
      case (m)
         MODE_OFFER: begin
            if (shadow_count < DEPTH) begin
               p = shadow_count;
               // equal keys stay in arrival order
               while (p > 0 && k < shadow_keys[p - 1]) p--;
               for (int i = shadow_count; i > p; i--) begin
                  shadow_keys[i] = shadow_keys[i - 1];
                  shadow_tags[i] = shadow_tags[i - 1];
               end
               shadow_keys[p] = k;
               shadow_tags[p] = t;
               shadow_count++;
               a.ok = 1'b1;
               a.position = 6'(p);
            end
         end
         MODE_POLL, MODE_PEEK: begin
            if (shadow_count > 0) begin
               a.ok = 1'b1;
               a.key_out = shadow_keys[0];
               a.tag_out = shadow_tags[0];
               if (m == MODE_POLL) shadow_delete(0);
            end
         end
         MODE_READ, MODE_REMOVE_AT: begin
            if (int'(ix) < shadow_count) begin
               a.ok = 1'b1;
               a.key_out = shadow_keys[ix];
               a.tag_out = shadow_tags[ix];
               if (m == MODE_REMOVE_AT) shadow_delete(ix);
            end
         end
         MODE_REMOVE_TAG: begin
            w = 0;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_tags[i] == t) begin
                  a.removed_count++;
               end else begin
                  shadow_keys[w] = shadow_keys[i];
                  shadow_tags[w] = shadow_tags[i];
                  w++;
               end
            end
            shadow_count = w;
            a.ok = (a.removed_count != 0);
         end
         MODE_SIZE: a.ok = 1'b1;
         default: ;
      endcase
      a.count = 7'(shadow_count);
      return a;
   endfunction

   // one transfer on the command side, with an optional random gap first
   task automatic issue_op(logic [2:0] m, logic [15:0] k, logic [15:0] t,
                           logic [5:0] ix);
      int gap;
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= m;
      req_key   <= k;
      req_tag   <= t;
      req_index <= ix;
      @(posedge clock);
      while (busy) @(posedge clock);
      answers_due.push_back(queue_answer(m, k, t, ix));
   endtask

   task automatic park();
      start <= 1'b0;
   endtask

   // check every result against the oldest answer due
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_ok, rsp_position, rsp_key_out, rsp_tag_out, rsp_removed_count,
                rsp_count};
         if (answers_due.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            errors++;
         end else begin
            want = answers_due.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected ok=%0d pos=%0d key=%h tag=%h rem=%0d cnt=%0d",
                        $time, want.ok, want.position, want.key_out, want.tag_out,
                        want.removed_count, want.count);
               $display("%0t:          actual   ok=%0d pos=%0d key=%h tag=%h rem=%0d cnt=%0d",
                        $time, got.ok, got.position, got.key_out, got.tag_out,
                        got.removed_count, got.count);
               errors++;
            end
         end
      end
   end

   // empty queue, extremes of the fields, every mode
   task automatic test_directed();
      issue_op(MODE_POLL, 16'h0, 16'h0, 6'd0);
      issue_op(MODE_PEEK, 16'h0, 16'h0, 6'd0);
      issue_op(MODE_READ, 16'h0, 16'h0, 6'd0);
      issue_op(MODE_REMOVE_AT, 16'h0, 16'h0, 6'd63);
      issue_op(MODE_REMOVE_TAG, 16'h0, 16'hFFFF, 6'd0);
      issue_op(MODE_OFFER, 16'hFFFF, 16'hFFFF, 6'd63);
      issue_op(MODE_OFFER, 16'h0000, 16'h0000, 6'd0);
      issue_op(MODE_OFFER, 16'h8000, 16'hAAAA, 6'd0);
      issue_op(MODE_OFFER, 16'h8000, 16'h5555, 6'd0);  // equal keys keep order
      issue_op(MODE_OFFER, 16'h8000, 16'hAAAA, 6'd0);
      issue_op(MODE_READ, 16'h0, 16'h0, 6'd2);
      issue_op(MODE_READ, 16'h0, 16'h0, 6'd5);   // just past the end
      issue_op(MODE_REMOVE_TAG, 16'h0, 16'hAAAA, 6'd0);  // split matches
      issue_op(MODE_REMOVE_AT, 16'h0, 16'h0, 6'd1);
      issue_op(MODE_PEEK, 16'h0, 16'h0, 6'd0);
      issue_op(MODE_POLL, 16'h0, 16'h0, 6'd0);
      issue_op(MODE_SIZE, 16'hFFFF, 16'hFFFF, 6'd63);
      issue_op(3'd7, 16'h1234, 16'h5678, 6'd9);   // unknown mode
      issue_op(MODE_REMOVE_TAG, 16'h0, 16'hFFFF, 6'd0);
   endtask

   // fill past full, offers beyond DEPTH are refused
   task automatic test_full_queue();
      while (shadow_count < DEPTH)
         issue_op(MODE_OFFER, 16'($urandom_range(0, 15)), 16'($urandom_range(0, 7)), 6'd0);
      issue_op(MODE_OFFER, 16'h0, 16'h1, 6'd0);
      issue_op(MODE_READ, 16'h0, 16'h0, 6'd63);
      issue_op(MODE_REMOVE_AT, 16'h0, 16'h0, 6'd63);
      issue_op(MODE_REMOVE_TAG, 16'h0, 16'($urandom_range(0, 7)), 6'd0);
      while (shadow_count > 0) issue_op(MODE_POLL, 16'h0, 16'h0, 6'd0);
   endtask

   // random traffic with repeated tags
   task automatic test_random(int n);
      logic [2:0]  m;
      logic [15:0] k;
      logic [15:0] t;
      for (int i = 0; i < n; i++) begin
         if (i > n - 80) no_gaps = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: m = MODE_OFFER;
            4: m = MODE_POLL;
            5: m = MODE_PEEK;
            6: m = MODE_READ;
            7: m = MODE_REMOVE_AT;
            8: m = ($urandom_range(0, 2) == 0) ? MODE_REMOVE_TAG : MODE_SIZE;
            default: m = 3'($urandom_range(0, 7));
         endcase
         k = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
         t = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 9)) : 16'($urandom);
         issue_op(m, k, t, 6'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      errors    = 0;
      no_gaps   = 1'b0;
      shadow_count = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_mode  = '0;
      req_key   = '0;
      req_tag   = '0;
      req_index = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_queue();
      test_random(600);
      park();
      // a remove tag may still be running; wait for its result
      for (int c = 0; c < 200 && answers_due.size() != 0; c++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0 && answers_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
